@@ rtl/m3inv_pkg.sv @@
package m3inv_pkg;

    localparam int ELEM_W  = 32;
    localparam int PROD_W  = 64;
    localparam int ADJ_W   = 65;
    localparam int DET_W   = 97;
    localparam int DABS_W  = 96;
    localparam int QBITS   = 33;
    localparam int COF_LAT = 2;
    localparam int DET_LAT = 3;
    localparam int DIV_LAT = QBITS + 3;

    localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [ELEM_W-1:0] in_r0c0;
        logic signed [ELEM_W-1:0] in_r0c1;
        logic signed [ELEM_W-1:0] in_r0c2;
        logic signed [ELEM_W-1:0] in_r1c0;
        logic signed [ELEM_W-1:0] in_r1c1;
        logic signed [ELEM_W-1:0] in_r1c2;
        logic signed [ELEM_W-1:0] in_r2c0;
        logic signed [ELEM_W-1:0] in_r2c1;
        logic signed [ELEM_W-1:0] in_r2c2;
    } t_mat_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv_r0c0;
        logic signed [ELEM_W-1:0] inv_r0c1;
        logic signed [ELEM_W-1:0] inv_r0c2;
        logic signed [ELEM_W-1:0] inv_r1c0;
        logic signed [ELEM_W-1:0] inv_r1c1;
        logic signed [ELEM_W-1:0] inv_r1c2;
        logic signed [ELEM_W-1:0] inv_r2c0;
        logic signed [ELEM_W-1:0] inv_r2c1;
        logic signed [ELEM_W-1:0] inv_r2c2;
        logic                     singular;
    } t_mat_out;

    typedef logic signed [ADJ_W-1:0]  t_adj;
    typedef logic signed [ELEM_W-1:0] t_elem;

endpackage

@@ rtl/m3inv_cofactor.sv @@
module m3inv_cofactor
    import m3inv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_mat_in i_mat,
    output logic    o_valid,
    output t_adj    o_adj [9],
    output t_elem   o_row0 [3]
);

    localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    t_elem m [9];
    logic signed [PROD_W-1:0] r_p1 [9];
    logic signed [PROD_W-1:0] r_p2 [9];
    t_elem r_row_a [3];
    logic  r_va;
    logic  r_vb;

    assign m[0] = i_mat.in_r0c0;
    assign m[1] = i_mat.in_r0c1;
    assign m[2] = i_mat.in_r0c2;
    assign m[3] = i_mat.in_r1c0;
    assign m[4] = i_mat.in_r1c1;
    assign m[5] = i_mat.in_r1c2;
    assign m[6] = i_mat.in_r2c0;
    assign m[7] = i_mat.in_r2c1;
    assign m[8] = i_mat.in_r2c2;

    for (genvar k = 0; k < 9; k++) begin : g_cof
        always_ff @(posedge i_clk) begin
            r_p1[k] <= PROD_W'(m[IA[k]]) * PROD_W'(m[IB[k]]);
            r_p2[k] <= PROD_W'(m[IC[k]]) * PROD_W'(m[ID[k]]);
            o_adj[k] <= {r_p1[k][PROD_W-1], r_p1[k]} - {r_p2[k][PROD_W-1], r_p2[k]};
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_row
        always_ff @(posedge i_clk) begin
            r_row_a[j] <= m[j];
            o_row0[j]  <= r_row_a[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    assign o_valid = r_vb;

endmodule

@@ rtl/m3inv_det.sv @@
module m3inv_det
    import m3inv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_elem                   i_row0 [3],
    input  t_adj                    i_cof [3],
    output logic                    o_valid,
    output logic signed [DET_W-1:0] o_det
);

    localparam int LO_W = ADJ_W - ELEM_W;
    localparam int PL_W = ELEM_W + LO_W + 1;

    logic signed [ELEM_W+LO_W:0]  r_pl [3];
    logic signed [PROD_W-1:0]     r_ph [3];
    logic signed [DET_W-1:0]      r_term [3];
    logic [2:0] r_v;

    for (genvar k = 0; k < 3; k++) begin : g_term
        always_ff @(posedge i_clk) begin
            r_pl[k]   <= PL_W'(i_row0[k]) * PL_W'($signed({1'b0, i_cof[k][LO_W-1:0]}));
            r_ph[k]   <= PROD_W'(i_row0[k]) * PROD_W'($signed(i_cof[k][ADJ_W-1:LO_W]));
            r_term[k] <= {r_ph[k], {LO_W{1'b0}}}
                       + {{(DET_W-ELEM_W-LO_W-1){r_pl[k][ELEM_W+LO_W]}}, r_pl[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        o_det <= r_term[0] + r_term[1] + r_term[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];

endmodule

@@ rtl/m3inv_div.sv @@
module m3inv_div
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_adj                    i_adj,
    input  logic signed [DET_W-1:0] i_det,
    output logic                    o_valid,
    output logic                    o_zero,
    output t_elem                   o_q
);

    localparam int NW = PROD_W + 2 * FRAC_BITS;
    localparam int RW = (NW > DABS_W + QBITS) ? NW : DABS_W + QBITS;

    logic [NW-1:0]     r_an;
    logic [DABS_W-1:0] r_ad;
    logic              r_sa;
    logic              r_za;
    logic              r_va;
    logic [PROD_W-1:0] n_aabs;
    logic [DABS_W-1:0] n_dabs;

    logic [RW-1:0]     r_rem [QBITS+1];
    logic [DABS_W-1:0] r_den [QBITS+1];
    logic [QBITS-1:0]  r_q   [QBITS+1];
    logic              r_neg [QBITS+1];
    logic              r_ovf [QBITS+1];
    logic              r_zr  [QBITS+1];
    logic              r_vs  [QBITS+1];

    always_comb begin
        n_aabs = PROD_W'(i_adj[ADJ_W-1] ? -i_adj : i_adj);
        n_dabs = DABS_W'(i_det[DET_W-1] ? -i_det : i_det);
    end

    always_ff @(posedge i_clk) begin
        r_an <= {n_aabs, {(2*FRAC_BITS){1'b0}}};
        r_ad <= n_dabs;
        r_sa <= i_adj[ADJ_W-1] ^ i_det[DET_W-1];
        r_za <= (i_det == '0);
        r_rem[0] <= RW'(r_an);
        r_den[0] <= r_ad;
        r_q[0]   <= '0;
        r_neg[0] <= r_sa;
        r_zr[0]  <= r_za;
        r_ovf[0] <= RW'(r_an) >= (RW'(r_ad) << QBITS);
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_step
        logic [RW-1:0] n_sh;
        logic          n_ge;
        assign n_sh = RW'(r_den[k-1]) << (QBITS - k);
        assign n_ge = r_rem[k-1] >= n_sh;
        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? r_rem[k-1] - n_sh : r_rem[k-1];
            r_q[k]   <= r_q[k-1] | (QBITS'(n_ge) << (QBITS - k));
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
            r_zr[k]  <= r_zr[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[k] <= 1'b0;
            end else begin
                r_vs[k] <= r_vs[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_zr[QBITS]) begin
            o_q <= '0;
        end else if (r_neg[QBITS]) begin
            if (r_ovf[QBITS] || r_q[QBITS] > QBITS'(SAT_MIN)) begin
                o_q <= SAT_MIN;
            end else begin
                o_q <= -r_q[QBITS][ELEM_W-1:0];
            end
        end else begin
            if (r_ovf[QBITS] || r_q[QBITS] > QBITS'(SAT_MAX)) begin
                o_q <= SAT_MAX;
            end else begin
                o_q <= r_q[QBITS][ELEM_W-1:0];
            end
        end
        o_zero <= r_zr[QBITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vs[0] <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_va    <= i_valid;
            r_vs[0] <= r_va;
            o_valid <= r_vs[QBITS];
        end
    end

endmodule

@@ rtl/matrix3x3_inverse_top.sv @@
// 3x3 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// Input: drive i_matrix and raise start; the transaction is taken at the
// clock edge where start is high and busy is low. busy stays low, so a new
// matrix may enter on every cycle.
// Output: o_valid is high for exactly one cycle with o_result, the nine
// inverse elements (truncated toward zero, saturated to 32 bits) and the
// singular flag; on a zero determinant all elements are zero.
// From start to o_valid a matrix passes the cofactors, then the determinant,
// then the divider (sign split, overflow check, one restoring quotient bit
// per stage for 33 bits, saturation).
// Throughput is one matrix per cycle; nine divider pipelines run side by side.
// Reset (synchronous, active low) clears every valid bit; matrices in flight
// are dropped. The receiver cannot stall, so results are never held.
module matrix3x3_inverse_top
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_mat_in  i_matrix,
    output logic     o_valid,
    output t_mat_out o_result
);

    localparam int LAT = COF_LAT + DET_LAT + DIV_LAT;

    logic  cof_valid;
    t_adj  cof_adj [9];
    t_elem cof_row [3];
    t_adj  det_cof [3];
    logic  det_valid;
    logic signed [DET_W-1:0] det_val;
    t_adj  r_adj_d [DET_LAT][9];
    logic  div_valid;
    logic  div_zero;
    t_elem div_q [9];

    assign busy = 1'b0;

    m3inv_cofactor u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_mat   (i_matrix),
        .o_valid (cof_valid),
        .o_adj   (cof_adj),
        .o_row0  (cof_row)
    );

    assign det_cof[0] = cof_adj[0];
    assign det_cof[1] = cof_adj[3];
    assign det_cof[2] = cof_adj[6];

    m3inv_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cof_valid),
        .i_row0  (cof_row),
        .i_cof   (det_cof),
        .o_valid (det_valid),
        .o_det   (det_val)
    );

    always_ff @(posedge i_clk) begin
        r_adj_d[0] <= cof_adj;
        for (int s = 1; s < DET_LAT; s++) begin
            r_adj_d[s] <= r_adj_d[s-1];
        end
    end

    m3inv_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (det_valid),
        .i_adj   (r_adj_d[DET_LAT-1][0]),
        .i_det   (det_val),
        .o_valid (div_valid),
        .o_zero  (div_zero),
        .o_q     (div_q[0])
    );

    for (genvar k = 1; k < 9; k++) begin : g_div
        m3inv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (det_valid),
            .i_adj   (r_adj_d[DET_LAT-1][k]),
            .i_det   (det_val),
            .o_valid (),
            .o_zero  (),
            .o_q     (div_q[k])
        );
    end

    assign o_valid           = div_valid;
    assign o_result.inv_r0c0 = div_q[0];
    assign o_result.inv_r0c1 = div_q[1];
    assign o_result.inv_r0c2 = div_q[2];
    assign o_result.inv_r1c0 = div_q[3];
    assign o_result.inv_r1c1 = div_q[4];
    assign o_result.inv_r1c2 = div_q[5];
    assign o_result.inv_r2c0 = div_q[6];
    assign o_result.inv_r2c1 = div_q[7];
    assign o_result.inv_r2c2 = div_q[8];
    assign o_result.singular = div_zero;

    a_result_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching start");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.singular) |-> (o_result[$bits(t_mat_out)-1:1] == '0))
        else $error("singular result with nonzero elements");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import m3inv_pkg::*;

    localparam int FRAC       = 16;
    localparam int ONE        = 1 << FRAC;
    localparam int N_RANDOM   = 850;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 60;

    typedef struct {
        t_mat_in  mat;
        bit       known;
        t_mat_out want;
    } t_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_mat_in  i_matrix;
    logic     o_valid;
    t_mat_out o_result;

    t_mat_out inverse_queue[$];
    int       errors;
    int       cycles;
    int       n_taken;
    int       n_checked;
    int       n_singular;
    int       n_saturated;

    matrix3x3_inverse_top #(.FRAC_BITS(FRAC)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_matrix (i_matrix),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [127:0] triple_prod(t_elem x, t_elem y, t_elem z);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        a = 128'(x);
        b = 128'(y);
        c = 128'(z);
        return a * b * c;
    endfunction

    function automatic logic signed [127:0] minor2(t_elem a, t_elem b, t_elem c, t_elem d);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] wc;
        logic signed [127:0] wd;
        wa = 128'(a);
        wb = 128'(b);
        wc = 128'(c);
        wd = 128'(d);
        return wa * wb - wc * wd;
    endfunction

    function automatic t_mat_out invert_matrix(t_mat_in m);
        t_elem               e[9];
        logic signed [127:0] det;
        logic signed [127:0] adj[9];
        logic signed [127:0] num;
        logic [127:0]        n;
        logic [127:0]        d;
        logic [127:0]        q;
        logic [31:0]         v[9];
        e[0] = m.in_r0c0; e[1] = m.in_r0c1; e[2] = m.in_r0c2;
        e[3] = m.in_r1c0; e[4] = m.in_r1c1; e[5] = m.in_r1c2;
        e[6] = m.in_r2c0; e[7] = m.in_r2c1; e[8] = m.in_r2c2;
        det = triple_prod(e[0], e[4], e[8]) + triple_prod(e[1], e[5], e[6])
            + triple_prod(e[2], e[3], e[7]) - triple_prod(e[2], e[4], e[6])
            - triple_prod(e[1], e[3], e[8]) - triple_prod(e[0], e[5], e[7]);
        adj[0] =  minor2(e[4], e[8], e[5], e[7]);
        adj[1] = -minor2(e[1], e[8], e[2], e[7]);
        adj[2] =  minor2(e[1], e[5], e[2], e[4]);
        adj[3] = -minor2(e[3], e[8], e[5], e[6]);
        adj[4] =  minor2(e[0], e[8], e[2], e[6]);
        adj[5] = -minor2(e[0], e[5], e[2], e[3]);
        adj[6] =  minor2(e[3], e[7], e[4], e[6]);
        adj[7] = -minor2(e[0], e[7], e[1], e[6]);
        adj[8] =  minor2(e[0], e[4], e[1], e[3]);
        if (det == 0)
            return {{9{32'd0}}, 1'b1};
        d = det[127] ? -det : det;
        for (int i = 0; i < 9; i++) begin
            num = adj[i] <<< (2 * FRAC);
            n = num[127] ? -num : num;
            q = n / d;
            if (num[127] ^ det[127])
                v[i] = (q > 128'h8000_0000) ? SAT_MIN : -q[31:0];
            else
                v[i] = (q > 128'h7FFF_FFFF) ? SAT_MAX : q[31:0];
        end
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], 1'b0};
    endfunction

    function automatic t_mat_in mat(int a, int b, int c, int d, int e, int f,
                                    int g, int h, int k);
        return {a, b, c, d, e, f, g, h, k};
    endfunction

    function automatic t_mat_out diag_inv(int x);
        return {x, 32'd0, 32'd0, 32'd0, x, 32'd0, 32'd0, 32'd0, x, 1'b0};
    endfunction

    function automatic int rnd_elem();
        case ($urandom_range(0, 3))
            0: return int'($urandom);
            1: return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
            2: return int'($urandom_range(0, 512)) - 256;
            default: return int'($urandom_range(0, 2 * ONE)) - ONE;
        endcase
    endfunction

    function automatic t_mat_in rnd_matrix();
        t_mat_in m;
        int      kind;
        kind = $urandom_range(0, 9);
        m = {rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
             rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
        if (kind == 0) begin
            m.in_r2c0 = m.in_r0c0;
            m.in_r2c1 = m.in_r0c1;
            m.in_r2c2 = m.in_r0c2;
        end else if (kind == 1) begin
            m.in_r0c1 = 0; m.in_r0c2 = 0; m.in_r1c0 = 0;
            m.in_r1c2 = 0; m.in_r2c0 = 0; m.in_r2c1 = 0;
        end else if (kind == 2) begin
            m.in_r0c0 = ONE + int'($urandom_range(0, 4096)) - 2048;
            m.in_r1c1 = ONE + int'($urandom_range(0, 4096)) - 2048;
            m.in_r2c2 = ONE + int'($urandom_range(0, 4096)) - 2048;
        end else if (kind == 3) begin
            m = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_mat_out want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (inverse_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                errors++;
            end else begin
                want = inverse_queue.pop_front();
                n_checked++;
                if (want.singular) n_singular++;
                for (int i = 0; i < 9; i++) begin
                    if (o_result[1 + 32 * (8 - i) +: 32] !== want[1 + 32 * (8 - i) +: 32]) begin
                        $display("%0t: element r%0dc%0d expected %h actual %h", $time,
                                 i / 3, i % 3, want[1 + 32 * (8 - i) +: 32],
                                 o_result[1 + 32 * (8 - i) +: 32]);
                        errors++;
                    end
                    if (want[1 + 32 * (8 - i) +: 32] inside {SAT_MAX, SAT_MIN})
                        n_saturated++;
                end
                if (o_result.singular !== want.singular) begin
                    $display("%0t: singular expected %b actual %b", $time,
                             want.singular, o_result.singular);
                    errors++;
                end
            end
        end
    end

    task automatic send_matrix(t_mat_in m, bit known, t_mat_out want);
        int gap;
        bit took;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_matrix <= m;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
        if (known && want !== invert_matrix(m)) begin
            $display("%0t: table entry %h expected %h predicted %h", $time, m,
                     want, invert_matrix(m));
            errors++;
        end
        inverse_queue.push_back(known ? want : invert_matrix(m));
        n_taken++;
    endtask

    initial begin
        t_row     rows[$];
        t_mat_out none;
        errors = 0; cycles = 0; n_taken = 0; n_checked = 0;
        n_singular = 0; n_saturated = 0;
        none = '0;
        start    <= 1'b0;
        i_matrix <= '0;
        i_rst_n  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back('{mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1, diag_inv(ONE)});
        rows.push_back('{mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, {{9{32'd0}}, 1'b1}});
        rows.push_back('{mat(2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE), 1,
                         diag_inv(ONE / 2)});
        rows.push_back('{mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1, diag_inv(SAT_MAX)});
        rows.push_back('{mat(-1, 0, 0, 0, -1, 0, 0, 0, -1), 1, diag_inv(SAT_MIN)});
        rows.push_back('{mat(SAT_MIN, 0, 0, 0, SAT_MIN, 0, 0, 0, SAT_MIN), 1,
                         diag_inv(-2)});
        rows.push_back('{mat(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                             SAT_MAX, SAT_MAX, SAT_MAX), 1, {{9{32'd0}}, 1'b1}});
        rows.push_back('{mat(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                             SAT_MIN, SAT_MIN, SAT_MIN), 1, {{9{32'd0}}, 1'b1}});
        rows.push_back('{mat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                             7 * ONE, 8 * ONE, 9 * ONE), 1, {{9{32'd0}}, 1'b1}});
        rows.push_back('{mat(SAT_MAX, 0, 0, 0, SAT_MAX, 0, 0, 0, SAT_MAX), 0, none});
        rows.push_back('{mat(SAT_MIN, SAT_MAX, 0, 1, SAT_MIN, SAT_MAX, SAT_MAX, 1,
                             SAT_MIN), 0, none});
        rows.push_back('{mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 0, none});
        rows.push_back('{mat(2 * ONE, -ONE, 0, -ONE, 2 * ONE, -ONE, 0, -ONE,
                             2 * ONE), 0, none});
        rows.push_back('{mat(3, 0, 0, 0, 7, 0, 0, 0, -5), 0, none});
        rows.push_back('{mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE), 0, none});
        rows.push_back('{mat(-1, -1, -1, -1, -1, -1, -1, -1, -1), 0, none});
        rows.push_back('{mat(ONE, ONE / 2, ONE / 3, ONE / 2, ONE / 3, ONE / 4,
                             ONE / 3, ONE / 4, ONE / 5), 0, none});

        foreach (rows[i])
            send_matrix(rows[i].mat, rows[i].known, rows[i].want);
        for (int i = 0; i < N_RANDOM; i++)
            send_matrix(rnd_matrix(), 0, none);
        start <= 1'b0;

        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d matrices taken, %0d results checked (%0d singular, %0d saturated elements)",
                 n_taken, n_checked, n_singular, n_saturated);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
